// File: rtl/core/bkrf_pkg.sv
// ----------------------------------------------------------------------------
// bkrf_pkg
// Command codes, mode codes, beat layouts and slot decoding for the banked
// register file.
// ----------------------------------------------------------------------------
package bkrf_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 5;
    localparam int IDX_W    = 4;
    localparam int CMD_W    = 4;

    localparam int GEN_DEPTH = 31;
    localparam int SAV_DEPTH = 5;
    localparam int GEN_AW    = $clog2(GEN_DEPTH);
    localparam int SAV_AW    = $clog2(SAV_DEPTH);

    // Input beat: command, reg_index, write_value, mode_value, zero pad
    localparam int S_CMD_LSB  = 0;
    localparam int S_IDX_LSB  = S_CMD_LSB + CMD_W;
    localparam int S_VAL_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_MODE_LSB = S_VAL_LSB + DATA_W;
    localparam int S_USED_W   = S_MODE_LSB + MODE_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Result beat: read_data, current_mode, privileged, has_spsr, spsr_missing
    localparam int M_RD_LSB   = 0;
    localparam int M_MODE_LSB = M_RD_LSB + DATA_W;
    localparam int M_PRIV_BIT = M_MODE_LSB + MODE_W;
    localparam int M_HAS_BIT  = M_PRIV_BIT + 1;
    localparam int M_MISS_BIT = M_HAS_BIT + 1;
    localparam int M_TDATA_W  = M_MISS_BIT + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_BANKED = 4'd0,
        CMD_WR_BANKED = 4'd1,
        CMD_RD_USER   = 4'd2,
        CMD_WR_USER   = 4'd3,
        CMD_RD_CPSR   = 4'd4,
        CMD_WR_CPSR   = 4'd5,
        CMD_RD_SPSR   = 4'd6,
        CMD_WR_SPSR   = 4'd7,
        CMD_SET_MODE  = 4'd8
    } cmd_t;

    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    localparam logic [DATA_W-1:0] CPSR_RESET = 32'h0000_0010;

    // Base slots of each bank in the general store
    localparam logic [GEN_AW-1:0] SLOT_FIQ_R8  = 5'd16;
    localparam logic [GEN_AW-1:0] SLOT_IRQ_R13 = 5'd23;
    localparam logic [GEN_AW-1:0] SLOT_SVC_R13 = 5'd25;
    localparam logic [GEN_AW-1:0] SLOT_ABT_R13 = 5'd27;
    localparam logic [GEN_AW-1:0] SLOT_UND_R13 = 5'd29;

    typedef struct packed {
        logic              hit;
        logic [SAV_AW-1:0] slot;
    } spsr_sel_t;

    // Map an architectural register to its slot under the given mode.
    function automatic logic [GEN_AW-1:0] bank_slot(input logic [MODE_W-1:0] mode,
                                                    input logic [IDX_W-1:0]  idx);
        logic [GEN_AW-1:0] base;
        logic [GEN_AW-1:0] slot;
        base = SLOT_IRQ_R13;
        slot = GEN_AW'(idx);
        if (mode == MODE_FIQ) begin
            if (idx >= 4'd8 && idx <= 4'd14) begin
                slot = SLOT_FIQ_R8 + GEN_AW'(idx - 4'd8);
            end
        end else if (idx == 4'd13 || idx == 4'd14) begin
            case (mode)
                MODE_IRQ: base = SLOT_IRQ_R13;
                MODE_SVC: base = SLOT_SVC_R13;
                MODE_ABT: base = SLOT_ABT_R13;
                MODE_UND: base = SLOT_UND_R13;
                default:  base = '0;
            endcase
            if (mode == MODE_IRQ || mode == MODE_SVC || mode == MODE_ABT ||
                mode == MODE_UND) begin
                slot = base + GEN_AW'(idx[0] ^ 1'b1);
            end
        end
        return slot;
    endfunction

    // SPSR bank of the given mode; hit low when the mode has none.
    function automatic spsr_sel_t spsr_slot(input logic [MODE_W-1:0] mode);
        spsr_sel_t sel;
        sel.hit  = 1'b1;
        sel.slot = '0;
        case (mode)
            MODE_FIQ: sel.slot = SAV_AW'(0);
            MODE_IRQ: sel.slot = SAV_AW'(1);
            MODE_SVC: sel.slot = SAV_AW'(2);
            MODE_ABT: sel.slot = SAV_AW'(3);
            MODE_UND: sel.slot = SAV_AW'(4);
            default:  sel.hit  = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

// File: rtl/core/banked_register_file.sv
// ----------------------------------------------------------------------------
// banked_register_file
// ARMv5-style register file with per-mode banking of r8-r14, CPSR and SPSRs.
// ----------------------------------------------------------------------------
// Takes one command beat per cycle and presents its result beat from an
// output register: the beat is captured in an input register, decoded
// against the current CPSR mode, applied to the register file and status
// words, and the result lands in an output register in the same cycle the
// state updates. A command therefore sees every earlier command's effect,
// with no stall. The one-command-per-cycle rate is set by the single
// read/write port of the 31-entry register array and the mode decode in
// front of it; only a stalled result beat holds the input. Entries of the
// register array and the SPSRs hold garbage until written; CPSR resets to
// user mode.
module banked_register_file
    import bkrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] command, [7:4] reg_index, [39:8] write_value, [44:40] mode_value
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_data, [36:32] current_mode, [37] privileged,
    // [38] has_spsr, [39] spsr_missing
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 in_valid_reg;
    logic [S_USED_W-1:0]  in_data_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [DATA_W-1:0]    status_reg;
    logic [DATA_W-1:0]    status_next;

    logic [DATA_W-1:0]    gen_mem [GEN_DEPTH];
    logic [DATA_W-1:0]    sav_mem [SAV_DEPTH];

    logic                 advance;
    logic                 fire;

    cmd_t                 cmd;
    logic [IDX_W-1:0]     idx;
    logic [DATA_W-1:0]    wr_val;
    logic [MODE_W-1:0]    new_mode;
    logic [MODE_W-1:0]    mode;
    logic [MODE_W-1:0]    mode_after;

    logic [GEN_AW-1:0]    gen_addr;
    spsr_sel_t            spsr_sel;
    logic                 gen_we;
    logic                 sav_we;
    logic                 gen_re;
    logic                 sav_re;
    logic [DATA_W-1:0]    rd_data;
    logic                 missing;
    logic                 priv;
    logic                 has_spsr;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign cmd      = cmd_t'(in_data_reg[S_CMD_LSB +: CMD_W]);
    assign idx      = in_data_reg[S_IDX_LSB +: IDX_W];
    assign wr_val   = in_data_reg[S_VAL_LSB +: DATA_W];
    assign new_mode = in_data_reg[S_MODE_LSB +: MODE_W];
    assign mode     = status_reg[MODE_W-1:0];
    assign spsr_sel = spsr_slot(mode);

    // User-bank commands bypass the mode decode
    assign gen_addr = (cmd == CMD_RD_USER || cmd == CMD_WR_USER) ? GEN_AW'(idx)
                                                               : bank_slot(mode, idx);

    always_comb begin
        rd_data     = '0;
        missing     = 1'b0;
        gen_we      = 1'b0;
        sav_we      = 1'b0;
        gen_re      = 1'b0;
        sav_re      = 1'b0;
        status_next = status_reg;
        case (cmd)
            CMD_RD_BANKED, CMD_RD_USER: gen_re  = 1'b1;
            CMD_WR_BANKED, CMD_WR_USER: gen_we  = 1'b1;
            CMD_RD_CPSR:                rd_data = status_reg;
            CMD_WR_CPSR:                status_next = wr_val;
            CMD_RD_SPSR: begin
                missing = !spsr_sel.hit;
                sav_re  = spsr_sel.hit;
            end
            CMD_WR_SPSR: begin
                missing = !spsr_sel.hit;
                sav_we  = spsr_sel.hit;
            end
            CMD_SET_MODE: status_next = {status_reg[DATA_W-1:MODE_W], new_mode};
            default: ;
        endcase
    end

    assign mode_after = status_next[MODE_W-1:0];
    assign priv       = (mode_after != MODE_USR);
    assign has_spsr   = (mode_after != MODE_USR) && (mode_after != MODE_SYS);

    always_ff @(posedge aclk) begin
        if (fire && gen_we) begin
            gen_mem[gen_addr] <= wr_val;
        end
        if (fire && sav_we) begin
            sav_mem[spsr_sel.slot] <= wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[S_USED_W-1:0];
        end
        if (fire) begin
            if (gen_re) begin
                out_data_reg <= {missing, has_spsr, priv, mode_after, gen_mem[gen_addr]};
            end else if (sav_re) begin
                out_data_reg <= {missing, has_spsr, priv, mode_after,
                                 sav_mem[spsr_sel.slot]};
            end else begin
                out_data_reg <= {missing, has_spsr, priv, mode_after, rd_data};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= CPSR_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                status_reg <= status_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/core/bkrf_checker.sv
// ----------------------------------------------------------------------------
// bkrf_checker
// Port-level checks on the result beats of the banked register file.
// ----------------------------------------------------------------------------
module bkrf_checker
    import bkrf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [MODE_W-1:0] res_mode;
    logic              spsr_mode;

    assign res_mode  = m_tdata[M_MODE_LSB +: MODE_W];
    assign spsr_mode = (res_mode == MODE_FIQ) || (res_mode == MODE_IRQ) ||
                       (res_mode == MODE_SVC) || (res_mode == MODE_ABT) ||
                       (res_mode == MODE_UND);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An accepted command is followed by a result beat on the output
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result beat after an accepted command");

    a_priv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_PRIV_BIT] == (res_mode != MODE_USR))
        else $error("privileged flag disagrees with mode");

    a_has: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_HAS_BIT] ==
                     ((res_mode != MODE_USR) && (res_mode != MODE_SYS)))
        else $error("has_spsr flag disagrees with mode");

    // A missing SPSR only happens outside the five banked modes and reads zero
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_MISS_BIT] |->
            !spsr_mode && (m_tdata[M_RD_LSB +: DATA_W] == '0))
        else $error("spsr_missing in a mode that owns an SPSR");

endmodule

bind banked_register_file bkrf_checker u_bkrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/banked_register_file_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_register_file_checker
// Watches both streams of the banked register file, keeps its own copy of the
// registers, CPSR and SPSRs, predicts one result beat per command beat and
// compares each returned beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module banked_register_file_checker
    import bkrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [3:0] command, [7:4] reg_index, [39:8] write_value, [44:40] mode_value
    input  logic [S_TDATA_W-1:0] s_tdata,

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_data, [36:32] current_mode, [37] privileged,
    // [38] has_spsr, [39] spsr_missing
    input  logic [M_TDATA_W-1:0] m_tdata,

    output int                   pending,
    output int                   fail_count
);

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [MODE_W-1:0] mode;
        logic              privileged;
        logic              has_spsr;
        logic              spsr_missing;
    } result_t;

    logic [DATA_W-1:0] gen_regs  [GEN_DEPTH];
    logic [DATA_W-1:0] spsr_regs [SAV_DEPTH];
    logic [DATA_W-1:0] cpsr;

    result_t predicted_beats [$];
    int      errors = 0;

    function automatic int bank_index(input logic [MODE_W-1:0] mode,
                                      input logic [IDX_W-1:0]  idx);
        int r;
        r = int'(idx);
        if (mode == MODE_FIQ) begin
            if (r >= 8 && r <= 14) begin
                return 16 + r - 8;
            end
        end else if (r == 13 || r == 14) begin
            case (mode)
                MODE_IRQ: return 23 + r - 13;
                MODE_SVC: return 25 + r - 13;
                MODE_ABT: return 27 + r - 13;
                MODE_UND: return 29 + r - 13;
                default:  return r;
            endcase
        end
        return r;
    endfunction

    function automatic int spsr_index(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_FIQ: return 0;
            MODE_IRQ: return 1;
            MODE_SVC: return 2;
            MODE_ABT: return 3;
            MODE_UND: return 4;
            default:  return -1;
        endcase
    endfunction

    // Apply one command beat to the shadow state and form its result beat.
    function automatic result_t execute_command(input logic [S_TDATA_W-1:0] beat);
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic [MODE_W-1:0] new_mode;
        logic [MODE_W-1:0] mode;
        result_t           res;
        int                sbank;
        cmd      = beat[S_CMD_LSB  +: CMD_W];
        idx      = beat[S_IDX_LSB  +: IDX_W];
        val      = beat[S_VAL_LSB  +: DATA_W];
        new_mode = beat[S_MODE_LSB +: MODE_W];
        mode     = cpsr[MODE_W-1:0];
        sbank    = spsr_index(mode);
        res      = '0;
        case (cmd)
            CMD_RD_BANKED: res.read_data = gen_regs[bank_index(mode, idx)];
            CMD_WR_BANKED: gen_regs[bank_index(mode, idx)] = val;
            CMD_RD_USER:   res.read_data = gen_regs[idx];
            CMD_WR_USER:   gen_regs[idx] = val;
            CMD_RD_CPSR:   res.read_data = cpsr;
            CMD_WR_CPSR:   cpsr = val;
            CMD_RD_SPSR: begin
                if (sbank < 0) res.spsr_missing = 1'b1;
                else res.read_data = spsr_regs[sbank];
            end
            CMD_WR_SPSR: begin
                if (sbank < 0) res.spsr_missing = 1'b1;
                else spsr_regs[sbank] = val;
            end
            CMD_SET_MODE:  cpsr[MODE_W-1:0] = new_mode;
            default: ;
        endcase
        res.mode       = cpsr[MODE_W-1:0];
        res.privileged = (res.mode != MODE_USR);
        res.has_spsr   = (res.mode != MODE_USR) && (res.mode != MODE_SYS);
        return res;
    endfunction

    task automatic flag_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            cpsr = CPSR_RESET;
            predicted_beats.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_data    = m_tdata[M_RD_LSB +: DATA_W];
                got.mode         = m_tdata[M_MODE_LSB +: MODE_W];
                got.privileged   = m_tdata[M_PRIV_BIT];
                got.has_spsr     = m_tdata[M_HAS_BIT];
                got.spsr_missing = m_tdata[M_MISS_BIT];
                if (predicted_beats.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = predicted_beats.pop_front();
                    if (got.read_data !== want.read_data)
                        flag_field("read_data", want.read_data, got.read_data);
                    if (got.mode !== want.mode)
                        flag_field("current_mode", DATA_W'(want.mode), DATA_W'(got.mode));
                    if (got.privileged !== want.privileged)
                        flag_field("privileged", DATA_W'(want.privileged),
                                   DATA_W'(got.privileged));
                    if (got.has_spsr !== want.has_spsr)
                        flag_field("has_spsr", DATA_W'(want.has_spsr), DATA_W'(got.has_spsr));
                    if (got.spsr_missing !== want.spsr_missing)
                        flag_field("spsr_missing", DATA_W'(want.spsr_missing),
                                   DATA_W'(got.spsr_missing));
                end
            end
            if (s_tvalid && s_tready) begin
                predicted_beats.push_back(execute_command(s_tdata));
            end
        end
        pending    <= predicted_beats.size();
        fail_count <= errors;
    end

endmodule

// File: tb/tb_banked_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_register_file
// Drives command beats into the banked register file with random gaps and
// result back-pressure: a directed pass over modes, banks and SPSR corner
// cases, then random traffic that never reads a never-written entry.
// ----------------------------------------------------------------------------
module tb_banked_register_file;
    import bkrf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_MIN = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SPARE_MAX = 4'd15;
    localparam int RANDOM_BEATS   = 500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [3:0] command, [7:4] reg_index, [39:8] write_value, [44:40] mode_value
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] read_data, [36:32] current_mode, [37] privileged,
    // [38] has_spsr, [39] spsr_missing
    logic [M_TDATA_W-1:0] m_tdata;

    int  pending;
    int  fail_count;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    // Stimulus-side view of the mode and of which entries hold data
    logic [MODE_W-1:0] cur_mode = MODE_USR;
    bit                gen_written [GEN_DEPTH];
    bit                sav_written [SAV_DEPTH];

    banked_register_file dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    banked_register_file_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int slot_for(input logic [MODE_W-1:0] mode,
                                    input logic [IDX_W-1:0]  idx);
        int r;
        r = int'(idx);
        if (mode == MODE_FIQ && r >= 8 && r <= 14) return 16 + r - 8;
        if (r == 13 || r == 14) begin
            case (mode)
                MODE_IRQ: return 23 + r - 13;
                MODE_SVC: return 25 + r - 13;
                MODE_ABT: return 27 + r - 13;
                MODE_UND: return 29 + r - 13;
                default:  return r;
            endcase
        end
        return r;
    endfunction

    function automatic int spsr_for(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_FIQ: return 0;
            MODE_IRQ: return 1;
            MODE_SVC: return 2;
            MODE_ABT: return 3;
            MODE_UND: return 4;
            default:  return -1;
        endcase
    endfunction

    // Mostly architectural modes, sometimes any five-bit code.
    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 99) < 15) return MODE_W'($urandom);
        case ($urandom_range(0, 6))
            0:       return MODE_USR;
            1:       return MODE_FIQ;
            2:       return MODE_IRQ;
            3:       return MODE_SVC;
            4:       return MODE_ABT;
            5:       return MODE_UND;
            default: return MODE_SYS;
        endcase
    endfunction

    // Send one command beat; entered and left at a falling edge.
    task automatic issue(input logic [CMD_W-1:0]  cmd,
                         input logic [IDX_W-1:0]  idx,
                         input logic [DATA_W-1:0] val,
                         input logic [MODE_W-1:0] mval);
        logic [CMD_W-1:0]     op;
        logic [S_TDATA_W-1:0] beat;
        int                   slot;
        int                   sbank;
        op    = cmd;
        slot  = slot_for(cur_mode, idx);
        sbank = spsr_for(cur_mode);
        // turn a read of a never-written entry into a write of it
        if (op == CMD_RD_BANKED && !gen_written[slot]) op = CMD_WR_BANKED;
        if (op == CMD_RD_USER && !gen_written[idx]) op = CMD_WR_USER;
        if (op == CMD_RD_SPSR && sbank >= 0 && !sav_written[sbank]) op = CMD_WR_SPSR;
        case (op)
            CMD_WR_BANKED: gen_written[slot] = 1'b1;
            CMD_WR_USER:   gen_written[idx] = 1'b1;
            CMD_WR_SPSR:   if (sbank >= 0) sav_written[sbank] = 1'b1;
            CMD_WR_CPSR:   cur_mode = val[MODE_W-1:0];
            CMD_SET_MODE:  cur_mode = mval;
            default: ;
        endcase
        beat = '0;
        beat[S_CMD_LSB  +: CMD_W]  = op;
        beat[S_IDX_LSB  +: IDX_W]  = idx;
        beat[S_VAL_LSB  +: DATA_W] = val;
        beat[S_MODE_LSB +: MODE_W] = mval;
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic [MODE_W-1:0] mval;
        int                pick;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset state, SPSR access in user mode, user register extremes
        issue(CMD_RD_CPSR,   4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_RD_SPSR,   4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_WR_SPSR,   4'd0,  32'hFFFF_FFFF, 5'h1F);
        issue(CMD_WR_USER,   4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_WR_USER,   4'd15, 32'hFFFF_FFFF, 5'h1F);
        issue(CMD_RD_USER,   4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_RD_BANKED, 4'd15, 32'h0000_0000, 5'h00);
        issue(CMD_WR_BANKED, 4'd13, 32'hA5A5_5A5A, 5'h00);
        // FIQ banks r8..r14 and has its own SPSR
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, MODE_FIQ);
        issue(CMD_WR_BANKED, 4'd8,  32'h8888_0008, 5'h00);
        issue(CMD_WR_BANKED, 4'd14, 32'hEEEE_000E, 5'h00);
        issue(CMD_RD_BANKED, 4'd8,  32'h0000_0000, 5'h00);
        issue(CMD_RD_BANKED, 4'd15, 32'h0000_0000, 5'h00);
        issue(CMD_WR_SPSR,   4'd0,  32'hFFFF_FFFF, 5'h00);
        issue(CMD_RD_SPSR,   4'd0,  32'h0000_0000, 5'h00);
        // ABT r13 must stay apart from UND r13
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, MODE_ABT);
        issue(CMD_WR_BANKED, 4'd13, 32'h1357_9BDF, 5'h00);
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, MODE_UND);
        issue(CMD_WR_BANKED, 4'd13, 32'h2468_ACE0, 5'h00);
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, MODE_ABT);
        issue(CMD_RD_BANKED, 4'd13, 32'h0000_0000, 5'h00);
        // Unknown mode code: user registers, no SPSR
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_RD_BANKED, 4'd13, 32'h0000_0000, 5'h00);
        issue(CMD_RD_SPSR,   4'd0,  32'h0000_0000, 5'h00);
        // Full CPSR write lands in system mode; spare command does nothing
        issue(CMD_WR_CPSR,   4'd0,  32'hFFFF_FFFF, 5'h00);
        issue(CMD_RD_CPSR,   4'd0,  32'h0000_0000, 5'h00);
        issue(CMD_SPARE_MAX, 4'd15, 32'hFFFF_FFFF, 5'h1F);
        issue(CMD_SET_MODE,  4'd0,  32'h0000_0000, MODE_USR);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            steady <= (n >= 200 && n < 300);
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(8, 15))
                                               : IDX_W'($urandom);
            val  = $urandom;
            mval = MODE_W'($urandom);
            if      (pick < 20) cmd = CMD_RD_BANKED;
            else if (pick < 35) cmd = CMD_WR_BANKED;
            else if (pick < 45) cmd = CMD_RD_USER;
            else if (pick < 55) cmd = CMD_WR_USER;
            else if (pick < 60) cmd = CMD_RD_CPSR;
            else if (pick < 65) begin
                cmd = CMD_WR_CPSR;
                val[MODE_W-1:0] = pick_mode();
            end
            else if (pick < 73) cmd = CMD_RD_SPSR;
            else if (pick < 81) cmd = CMD_WR_SPSR;
            else if (pick < 95) begin
                cmd  = CMD_SET_MODE;
                mval = pick_mode();
            end
            else cmd = CMD_W'($urandom_range(CMD_SPARE_MIN, CMD_SPARE_MAX));
            issue(cmd, idx, val, mval);
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bkrf_pkg.sv
rtl/core/banked_register_file.sv
rtl/core/bkrf_checker.sv
tb/banked_register_file_checker.sv
tb/tb_banked_register_file.sv
